// ===== sv/ultrasonic_echo_ranger_bar_macros.svh =====
// Assertion helpers for the ranging controller
`ifndef ULTRASONIC_ECHO_RANGER_BAR_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_BAR_MACROS_SVH

// Same-cycle implication, sampled on the block clock outside reset
`define UERB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset
`define UERB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uerb_pkg.sv =====
package uerb_pkg;

    // Field and register widths
    localparam int TICK_W  = 16;
    localparam int CPT_W   = 6;
    localparam int DIST_W  = TICK_W + CPT_W;
    localparam int STEP_W  = 19;
    localparam int BAR_W   = 8;
    localparam int PHC_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int BAR_SEGMENTS_DEF = 8;

    // Register reset values
    localparam logic [PHC_W-1:0]  SETTLE_RST  = 8'd1;
    localparam logic [PHC_W-1:0]  TRIGGER_RST = 8'd4;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd2100;
    localparam logic [CPT_W-1:0]  CPT_RST     = 6'd49;
    localparam logic [STEP_W-1:0] STEP_RST    = 19'd12800;

    // Register map indexes (byte address / 4)
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_SETTLE  = 3'd0;
    localparam t_reg_idx REG_TRIGGER = 3'd1;
    localparam t_reg_idx REG_TIMEOUT = 3'd2;
    localparam t_reg_idx REG_CPT     = 3'd3;
    localparam t_reg_idx REG_STEP    = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_TRIG,
        PH_WAIT,
        PH_COUNT
    } t_phase;

    // Scaled result of one measurement
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [BAR_W-1:0]  bar;
    } t_meas;

endpackage

// ===== sv/uerb_if.sv =====
interface uerb_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source(output valid, start_req, echo_level, input ready);
    modport sink(input valid, start_req, echo_level, output ready);
endinterface

interface uerb_out_if
    import uerb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [TICK_W-1:0] echo_ticks;
    logic [DIST_W-1:0] distance_q10;
    logic [BAR_W-1:0]  bar_pattern;

    modport source(output valid, trigger_level, busy_res, done_res, echo_ticks,
                   distance_q10, bar_pattern, input ready);
    modport sink(input valid, trigger_level, busy_res, done_res, echo_ticks,
                 distance_q10, bar_pattern, output ready);
endinterface

// ===== sv/uerb_bar_calc.sv =====
module uerb_bar_calc
    import uerb_pkg::*;
#(
    parameter int BAR_SEGMENTS = BAR_SEGMENTS_DEF
) (
    input  logic [TICK_W-1:0] i_ticks,
    input  logic [CPT_W-1:0]  i_cm_per_tick,
    input  logic [STEP_W-1:0] i_bar_step,
    output t_meas             o_meas
);

    localparam int MULT_W = STEP_W + $clog2(BAR_SEGMENTS);
    localparam int CMP_W  = (MULT_W > DIST_W) ? MULT_W : DIST_W;

    logic [DIST_W-1:0]             distance;
    logic [STEP_W-1:0]             step_eff;
    logic [BAR_SEGMENTS-1:0]       lit;
    logic [BAR_W+BAR_SEGMENTS-1:0] lit_ext;

    // Scale echo ticks to distance in 1/1024 cm
    assign distance = DIST_W'(i_ticks) * DIST_W'(i_cm_per_tick);

    // Treat a zero step as one
    assign step_eff = (i_bar_step == '0) ? STEP_W'(1) : i_bar_step;

    // Light segment k once the distance reaches k steps; segment 0 is always lit
    assign lit[0] = 1'b1;
    for (genvar k = 1; k < BAR_SEGMENTS; k++) begin : g_seg
        logic [CMP_W-1:0] threshold;
        assign threshold = CMP_W'(k) * CMP_W'(step_eff);
        assign lit[k]    = CMP_W'(distance) >= threshold;
    end

    // Keep the low bar bits only
    assign lit_ext = {BAR_W'(0), lit};

    assign o_meas.distance = distance;
    assign o_meas.bar      = lit_ext[BAR_W-1:0];

endmodule

// ===== sv/ultrasonic_echo_ranger_bar.sv =====
// Flow: a transaction enters the input register when the input is ready; its result
// moves to the result registers once the result slot is free, and is held until taken.
// Throughput: one transaction per clock unless a held result is not taken; the phase update
// and the 16x6 scaling multiply with bar compares fit between the input and result registers.
// Reset (synchronous, active low): phase idle, counters and last result cleared,
// bar shows one segment, configuration registers return to their defaults.
`include "ultrasonic_echo_ranger_bar_macros.svh"

module ultrasonic_echo_ranger_bar
    import uerb_pkg::*;
#(
    parameter int BAR_SEGMENTS = BAR_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uerb_in_if.sink           i_in,
    uerb_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic [PHC_W-1:0]  r_settle;
    logic [PHC_W-1:0]  r_trigger;
    logic [TICK_W-1:0] r_timeout;
    logic [CPT_W-1:0]  r_cpt;
    logic [STEP_W-1:0] r_step;

    // Input stage
    logic r_in_valid;
    logic r_in_start;
    logic r_in_echo;

    // Measurement state
    t_phase            r_phase, n_phase;
    logic [PHC_W-1:0]  r_phase_count, n_phase_count;
    logic [TICK_W-1:0] r_tick_count, n_tick_count;
    logic [TICK_W-1:0] r_last_ticks, n_last_ticks;
    logic [DIST_W-1:0] r_last_dist, n_last_dist;
    logic [BAR_W-1:0]  r_last_bar, n_last_bar;
    logic              r_out_done, n_done;
    logic              r_out_valid;

    logic              advance;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;
    logic [PHC_W-1:0]  settle_eff;
    logic [PHC_W-1:0]  trigger_eff;
    t_meas             meas;

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle  <= SETTLE_RST;
            r_trigger <= TRIGGER_RST;
            r_timeout <= TIMEOUT_RST;
            r_cpt     <= CPT_RST;
            r_step    <= STEP_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SETTLE:  r_settle  <= pwdata[PHC_W-1:0];
                REG_TRIGGER: r_trigger <= pwdata[PHC_W-1:0];
                REG_TIMEOUT: r_timeout <= pwdata[TICK_W-1:0];
                REG_CPT:     r_cpt     <= pwdata[CPT_W-1:0];
                REG_STEP:    r_step    <= pwdata[STEP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_SETTLE:  prdata = DATA_W'(r_settle);
            REG_TRIGGER: prdata = DATA_W'(r_trigger);
            REG_TIMEOUT: prdata = DATA_W'(r_timeout);
            REG_CPT:     prdata = DATA_W'(r_cpt);
            REG_STEP:    prdata = DATA_W'(r_step);
            default:     prdata = '0;
        endcase
    end

    // Advance the held transaction when the result slot is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_start <= i_in.start_req;
            r_in_echo  <= i_in.echo_level;
        end
    end

    // Scale the running count; used only when the measurement completes
    uerb_bar_calc #(
        .BAR_SEGMENTS(BAR_SEGMENTS)
    ) u_bar_calc (
        .i_ticks      (r_tick_count),
        .i_cm_per_tick(r_cpt),
        .i_bar_step   (r_step),
        .o_meas       (meas)
    );

    assign settle_eff  = (r_settle == '0) ? PHC_W'(1) : r_settle;
    assign trigger_eff = (r_trigger == '0) ? PHC_W'(1) : r_trigger;

    // Next phase and measurement outputs
    always_comb begin
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_tick_count  = r_tick_count;
        n_last_ticks  = r_last_ticks;
        n_last_dist   = r_last_dist;
        n_last_bar    = r_last_bar;
        n_done        = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_in_start) begin
                    n_phase       = PH_SETTLE;
                    n_phase_count = PHC_W'(1);
                end
            end
            PH_SETTLE: begin
                if (r_phase_count >= settle_eff) begin
                    n_phase       = PH_TRIG;
                    n_phase_count = PHC_W'(1);
                end else begin
                    n_phase_count = r_phase_count + PHC_W'(1);
                end
            end
            PH_TRIG: begin
                if (r_phase_count >= trigger_eff) begin
                    n_phase       = PH_WAIT;
                    n_phase_count = '0;
                end else begin
                    n_phase_count = r_phase_count + PHC_W'(1);
                end
            end
            PH_WAIT: begin
                if (r_in_echo) begin
                    n_phase      = PH_COUNT;
                    n_tick_count = '0;
                end
            end
            PH_COUNT: begin
                if (!r_in_echo || (r_timeout != '0 && r_tick_count >= r_timeout)) begin
                    n_last_ticks  = r_tick_count;
                    n_last_dist   = meas.distance;
                    n_last_bar    = meas.bar;
                    n_phase       = PH_IDLE;
                    n_phase_count = '0;
                    n_done        = 1'b1;
                end else if (r_tick_count != '1) begin
                    n_tick_count = r_tick_count + TICK_W'(1);
                end
            end
            default: begin
                n_phase       = PH_IDLE;
                n_phase_count = '0;
            end
        endcase
    end

    // State register; updates only as a transaction moves to the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_count <= '0;
            r_tick_count  <= '0;
            r_last_ticks  <= '0;
            r_last_dist   <= '0;
            r_last_bar    <= BAR_W'(1);
            r_out_done    <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_tick_count  <= n_tick_count;
            r_last_ticks  <= n_last_ticks;
            r_last_dist   <= n_last_dist;
            r_last_bar    <= n_last_bar;
            r_out_done    <= n_done;
        end
    end

    // Result slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result fields show the state after the transaction
    assign o_out.valid         = r_out_valid;
    assign o_out.trigger_level = (r_phase == PH_TRIG);
    assign o_out.busy_res      = (r_phase != PH_IDLE);
    assign o_out.done_res      = r_out_done;
    assign o_out.echo_ticks    = r_last_ticks;
    assign o_out.distance_q10  = r_last_dist;
    assign o_out.bar_pattern   = r_last_bar;

    `UERB_ASSERT_SAME(a_idle_count_clear, r_phase == PH_IDLE, r_phase_count == '0, "phase count not clear while idle")
    `UERB_ASSERT_NEXT(a_echo_fall_done, advance && r_phase == PH_COUNT && !r_in_echo, r_out_done && r_phase == PH_IDLE, "echo fall did not complete the measurement")
    `UERB_ASSERT_SAME(a_bar_base_lit, r_out_valid, r_last_bar[0], "first bar segment dark")

endmodule
